// File: src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared codes, defaults and types for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed field widths of the request and result transactions
  localparam int REQ_W    = 2;
  localparam int FIELD_W  = 6;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // insert accepted: shift up from the target slot
    logic del;  // delete accepted: shift down into the target slot
  } sle_ctrl_t;

endpackage

// File: src/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds a word, takes a neighbour's word on a shift and
// flags a match against the search value.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int IDX = 0,
  parameter int DW  = 32,
  parameter int CW  = 6,
  parameter int PW  = 6
) (
  input  logic              clk_i,
  input  sle_pkg::sle_ctrl_t ctrl_i,
  input  logic [PW-1:0]     pidx_i,   // 0-based target slot
  input  logic [CW-1:0]     count_i,
  input  logic [DW-1:0]     value_i,
  input  logic [DW-1:0]     left_i,
  input  logic [DW-1:0]     right_i,
  output logic [DW-1:0]     data_o,
  output logic              match_o
);
  import sle_pkg::*;

  localparam logic [PW-1:0] IDX_P = PW'(IDX);

  logic [DW-1:0] data_q;
  logic [DW-1:0] data_d;
  logic          occupied;

  assign occupied = IDX_P < PW'(count_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (IDX_P > pidx_i) begin
        data_d = left_i;
      end else if (IDX_P == pidx_i) begin
        data_d = value_i;
      end
    end else if (ctrl_i.del) begin
      if (IDX_P >= pidx_i) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = occupied && (data_q == value_i);

endmodule

// File: src/sequential_list_engine_top.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// Fixed-capacity ordered list with insert, delete and locate, built as a
// row of slot cells that shift in parallel.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake               | payload
//   request  | in        | in_valid_i / in_stall_o | req_type_i, position_i, value_i
//   result   | out       | out_valid_o/out_stall_i | status_o, found_position_o,
//            |           |                         | list_length_o
//
// One transaction per cycle while in_stall_o is low. All cells shift or
// compare in the cycle of acceptance; the match vector is registered and
// reduced to a position by a find-first in the next cycle, so a result
// passes the pending stage and the output register before it is offered.
// Reset clears the length; slot contents are left as they are.
// A stalled result holds in the output register with one more transaction
// held behind it; the request side stalls only when both are full.
module sequential_list_engine_top #(
  parameter int CAPACITY   = sle_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = sle_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sle_pkg::REQ_W-1:0]         req_type_i,
  input  logic [sle_pkg::FIELD_W-1:0]       position_i,
  input  logic signed [DATA_WIDTH-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sle_pkg::STATUS_W-1:0]      status_o,
  output logic [sle_pkg::FIELD_W-1:0]       found_position_o,
  output logic [sle_pkg::FIELD_W-1:0]       list_length_o
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int XW = PW + 1;

  logic [CW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] match;

  // pending stage
  logic                pend_q;
  logic [CAPACITY-1:0] match_q;
  logic                loc_q;
  logic [STATUS_W-1:0] status_q;
  logic [CW-1:0]       len_q;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FIELD_W-1:0]  out_found_q;
  logic [FIELD_W-1:0]  out_len_q;

  logic                accept;
  logic                advance;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;
  logic                ins_ok, del_ok;
  logic [STATUS_W-1:0] status_d;
  logic [PW-1:0]       pidx;
  sle_ctrl_t           ctrl;
  logic [CAPACITY-1:0] first_hit;
  logic [PW-1:0]       found_full;

  assign advance    = pend_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = pend_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_x = XW'(position_i);
  assign cnt_x = XW'(count_q);
  assign pidx  = PW'(pos_x - XW'(1));

  always_comb begin
    status_d = ST_OK;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    case (req_type_i)
      REQ_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
          status_d = ST_RANGE;
        end else if (cnt_x >= XW'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      REQ_LOCATE: status_d = ST_OK;
      default:    status_d = ST_RANGE;
    endcase
  end

  assign ctrl.ins = accept && ins_ok;
  assign ctrl.del = accept && del_ok;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (k == 0) begin : g_head
      assign left_data = value_i;
    end else begin : g_body
      assign left_data = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[k];
    end else begin : g_inner
      assign right_data = cell_data[k+1];
    end

    sle_cell #(
      .IDX (k),
      .DW  (DATA_WIDTH),
      .CW  (CW),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pidx_i  (pidx),
      .count_i (count_q),
      .value_i (value_i),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[k]),
      .match_o (match[k])
    );
  end

  // isolate the lowest set bit, then encode it
  assign first_hit = match_q & (~match_q + CAPACITY'(1));

  always_comb begin
    found_full = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (first_hit[k]) begin
        found_full = found_full | PW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (advance) begin
        pend_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      match_q  <= match;
      loc_q    <= (req_type_i == REQ_LOCATE);
      status_q <= status_d;
      len_q    <= count_d;
    end
    if (advance) begin
      out_status_q <= status_q;
      out_found_q  <= loc_q ? found_full[FIELD_W-1:0] : '0;
      out_len_q    <= FIELD_W'(len_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign list_length_o    = out_len_q;

  // length never exceeds the number of cells
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  // a successful insert grows the list by exactly one
  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ins_ok) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list");

  // a failed request leaves the length unchanged
  a_fail_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != ST_OK) |=> $stable(count_q))
    else $error("failed request changed the length");

  // a reported position comes with an OK status (only a locate reports one)
  a_found_locate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_position_o != '0) |-> (status_o == ST_OK))
    else $error("position reported on a failed request");

endmodule
